@@ src/dcq_pkg.sv @@
`timescale 1ns / 1ps
// dcq_pkg: shared types and constants for the duplicate-suppressing id queue
// depends on nothing; used by dcq_cell, dcq_ctrl and dedup_circular_id_queue_top
package dcq_pkg;

    localparam int DEPTH = 8;
    localparam int ID_W = 22;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_DUP   = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t              operation;
        logic [ID_W-1:0]  proc_id;
    } in_t;

    typedef struct packed {
        logic [ID_W-1:0]  result_id;
        logic             hit;
        status_t          status;
        logic [3:0]       count_after;
    } out_t;

    typedef struct packed {
        logic             shift;
        logic             load;
        logic [IDX_W-1:0] wpos;
        logic [ID_W-1:0]  load_id;
    } cell_ctrl_t;

endpackage

@@ src/dcq_cell.sv @@
`timescale 1ns / 1ps
// dcq_cell: one queue slot; loads a new id at its own position or takes its neighbor's id
// depends on dcq_pkg
module dcq_cell
    import dcq_pkg::*;
(
    input  logic             aclk,
    input  cell_ctrl_t       ctrl,
    input  logic [IDX_W-1:0] cell_idx,
    input  logic [ID_W-1:0]  right_id,
    output logic [ID_W-1:0]  id
);

    logic [ID_W-1:0] id_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load && (ctrl.wpos == cell_idx)) begin
            id_reg <= ctrl.load_id;
        end else if (ctrl.shift) begin
            id_reg <= right_id;
        end
    end

    assign id = id_reg;

endmodule

@@ src/dcq_ctrl.sv @@
`timescale 1ns / 1ps
// dcq_ctrl: sequencer; walks the row once unless pop or full insert; has the result register
// depends on dcq_pkg
module dcq_ctrl
    import dcq_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  in_t             s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output out_t            m_data,
    input  logic [ID_W-1:0] head_id,
    output cell_ctrl_t      cell_ctrl
);

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] orig_reg, orig_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic             found_reg, found_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg, m_data_next;
    logic             match;
    logic             fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        id_reg     <= id_next;
        orig_reg   <= orig_next;
        step_reg   <= step_next;
        found_reg  <= found_next;
        m_data_reg <= m_data_next;
    end

    assign match = (head_id == id_reg);
    assign fire  = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        len_next     = len_reg;
        orig_next    = orig_reg;
        step_next    = step_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        cell_ctrl    = '0;
        s_ready      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = s_data.operation;
                    id_next    = s_data.proc_id;
                    step_next  = '0;
                    found_next = 1'b0;
                    if ((s_data.operation == OP_POP) ||
                        ((s_data.operation == OP_INSERT) && (len_reg == FULL_CNT))) begin
                        orig_next = '0;
                    end else begin
                        orig_next = len_reg;
                    end
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (step_reg == orig_reg) begin
                    state_next = S_DONE;
                end else begin
                    // head entry leaves, survivors go back in at the tail
                    step_next       = step_reg + 1'b1;
                    found_next      = found_reg || match;
                    cell_ctrl.shift = 1'b1;
                    if ((op_reg == OP_REMOVE) && match) begin
                        len_next = len_reg - 1'b1;
                    end else begin
                        cell_ctrl.load    = 1'b1;
                        cell_ctrl.wpos    = IDX_W'(len_reg - 1'b1);
                        cell_ctrl.load_id = head_id;
                    end
                end
            end
            S_DONE: begin
                if (fire) begin
                    m_data_next = '0;
                    m_data_next.status = STAT_OK;
                    unique case (op_reg)
                        OP_INSERT: begin
                            if (len_reg == FULL_CNT) begin
                                m_data_next.status = STAT_FULL;
                            end else if (found_reg) begin
                                m_data_next.status = STAT_DUP;
                            end else begin
                                cell_ctrl.load    = 1'b1;
                                cell_ctrl.wpos    = IDX_W'(len_reg);
                                cell_ctrl.load_id = id_reg;
                                len_next          = len_reg + 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (len_reg == '0) begin
                                m_data_next.status = STAT_EMPTY;
                            end else begin
                                m_data_next.result_id = head_id;
                                m_data_next.hit       = 1'b1;
                                cell_ctrl.shift       = 1'b1;
                                len_next              = len_reg - 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            m_data_next.hit = (len_reg != orig_reg);
                        end
                        OP_LOOKUP: begin
                            if (found_reg) begin
                                m_data_next.hit       = 1'b1;
                                m_data_next.result_id = id_reg;
                            end
                        end
                        default: begin
                            m_data_next.status = STAT_OK;
                        end
                    endcase
                    m_data_next.count_after = 4'(len_next);
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= FULL_CNT)
        else $error("queue length above depth");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (step_reg <= orig_reg))
        else $error("walk ran past the starting length");

    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DONE) && fire) |=> (m_data_reg.count_after == 4'(len_reg)))
        else $error("reported count differs from queue length");

    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status == STAT_EMPTY)) |->
            (!m_data_reg.hit && (m_data_reg.count_after == 4'd0)))
        else $error("empty status with hit or nonzero count");

    a_remove_no_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_WALK) && (op_reg == OP_REMOVE)) |=> (len_reg <= $past(len_reg)))
        else $error("remove walk grew the queue");

endmodule

@@ src/dedup_circular_id_queue_top.sv @@
`timescale 1ns / 1ps
// after an input transfer the sequencer walks the queue (not for pop or full insert),
// then registers the result once the output register is empty or being read; a new input
// is taken only after the result of the last one is in the output register
// the walk moves every entry once through the head cell, one entry per cycle
// the next input transfer is taken while a result still waits on the output register
// reset (aresetn low, synchronous) empties the queue; slot contents are left as they are
// dedup_circular_id_queue_top: cell row plus sequencer; depends on dcq_pkg, dcq_cell, dcq_ctrl
module dedup_circular_id_queue_top
    import dcq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    cell_ctrl_t      cell_ctrl;
    logic [ID_W-1:0] cell_id [DEPTH];

    dcq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .head_id   (cell_id[0]),
        .cell_ctrl (cell_ctrl)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ID_W-1:0] right_id;
        if (g == DEPTH - 1) begin : g_last
            assign right_id = cell_id[g];
        end else begin : g_mid
            assign right_id = cell_id[g+1];
        end
        dcq_cell u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl),
            .cell_idx (IDX_W'(g)),
            .right_id (right_id),
            .id       (cell_id[g])
        );
    end

endmodule

@@ tb/tb_dedup_circular_id_queue_top.sv @@
`timescale 1ns / 1ps
// tb_dedup_circular_id_queue_top: self-checking testbench for the duplicate-suppressing id queue
// directed and random insert, pop, remove and lookup traffic against a queue predictor
// depends on dcq_pkg and dedup_circular_id_queue_top
module tb_dedup_circular_id_queue_top
    import dcq_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // predicted queue contents
    logic [ID_W-1:0] q_slots [DEPTH];
    int q_head = 0;
    int q_count = 0;

    out_t pending_results[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    int stall_left = 0;
    bit steady = 1'b0;

    dedup_circular_id_queue_top dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always #4 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic bit queue_holds(input logic [ID_W-1:0] id);
        for (int i = 0; i < q_count; i++) begin
            if (q_slots[(q_head + i) % DEPTH] == id) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic out_t predict_queue_op(input in_t item);
        out_t res;
        int kept;
        logic [ID_W-1:0] cur;
        res = '0;
        res.status = STAT_OK;
        case (item.operation)
            OP_INSERT: begin
                if (q_count >= DEPTH) begin
                    res.status = STAT_FULL;
                end else if (queue_holds(item.proc_id)) begin
                    res.status = STAT_DUP;
                end else begin
                    q_slots[(q_head + q_count) % DEPTH] = item.proc_id;
                    q_count++;
                end
            end
            OP_POP: begin
                if (q_count == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.result_id = q_slots[q_head];
                    res.hit = 1'b1;
                    q_count--;
                    q_head = (q_head + 1) % DEPTH;
                end
            end
            OP_REMOVE: begin
                kept = 0;
                for (int i = 0; i < q_count; i++) begin
                    cur = q_slots[(q_head + i) % DEPTH];
                    if (cur != item.proc_id) begin
                        q_slots[(q_head + kept) % DEPTH] = cur;
                        kept++;
                    end
                end
                res.hit = (kept != q_count);
                q_count = kept;
            end
            OP_LOOKUP: begin
                if (queue_holds(item.proc_id)) begin
                    res.hit = 1'b1;
                    res.result_id = item.proc_id;
                end
            end
            default: ;
        endcase
        res.count_after = 4'(q_count);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // input transfers feed the predictor, result transfers are checked in order
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && s_valid && s_ready) begin
            pending_results.push_back(predict_queue_op(s_data));
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result transfer with nothing pending: %h", m_data));
            end else begin
                want = pending_results.pop_front();
                if (m_data.result_id !== want.result_id) begin
                    report_mismatch($sformatf("result_id %h, want %h",
                                              m_data.result_id, want.result_id));
                end
                if (m_data.hit !== want.hit) begin
                    report_mismatch($sformatf("hit %b, want %b", m_data.hit, want.hit));
                end
                if (m_data.status !== want.status) begin
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_data.status, want.status));
                end
                if (m_data.count_after !== want.count_after) begin
                    report_mismatch($sformatf("count_after %0d, want %0d",
                                              m_data.count_after, want.count_after));
                end
            end
        end
    end

    // result channel back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            stall_left = pick_gap();
            m_ready <= (stall_left == 0);
            if (stall_left > 0) begin
                stall_left--;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_item(input op_t op, input logic [ID_W-1:0] id);
        int gap;
        in_t item;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        item.operation = op;
        item.proc_id = id;
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic test_empty_queue();
        send_item(OP_POP, '0);
        send_item(OP_REMOVE, ID_MAX);
        send_item(OP_LOOKUP, '0);
    endtask

    task automatic test_fill_to_full();
        send_item(OP_INSERT, '0);
        send_item(OP_INSERT, ID_MAX);
        send_item(OP_INSERT, '0);
        for (int k = 1; k <= 6; k++) begin
            send_item(OP_INSERT, ID_W'(k * 22'h05A5A5));
        end
        // full takes precedence over duplicate
        send_item(OP_INSERT, ID_MAX);
        send_item(OP_INSERT, 22'h123456);
        send_item(OP_LOOKUP, ID_MAX);
        send_item(OP_LOOKUP, 22'h123456);
    endtask

    task automatic test_remove_wraparound();
        send_item(OP_POP, '0);
        send_item(OP_POP, '0);
        send_item(OP_INSERT, 22'h0F0F0F);
        send_item(OP_INSERT, ID_MAX);
        send_item(OP_REMOVE, ID_W'(2 * 22'h05A5A5));
        send_item(OP_REMOVE, 22'h123456);
        send_item(OP_REMOVE, ID_MAX);
        send_item(OP_LOOKUP, 22'h0F0F0F);
    endtask

    // ids mostly come from a small pool so duplicates, hits and removals happen
    task automatic run_random_mix(input int n, input int w_ins, input int w_pop,
                                  input int w_rem);
        logic [ID_W-1:0] pool [10];
        logic [ID_W-1:0] id;
        op_t op;
        int r;
        foreach (pool[i]) begin
            pool[i] = ID_W'($urandom);
        end
        pool[0] = '0;
        pool[1] = ID_MAX;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            if (r < w_ins) begin
                op = OP_INSERT;
            end else if (r < w_ins + w_pop) begin
                op = OP_POP;
            end else if (r < w_ins + w_pop + w_rem) begin
                op = OP_REMOVE;
            end else begin
                op = OP_LOOKUP;
            end
            if ($urandom_range(0, 3) != 0) begin
                id = pool[$urandom_range(0, 9)];
            end else begin
                id = ID_W'($urandom);
            end
            send_item(op, id);
        end
    endtask

    task automatic test_random_traffic();
        run_random_mix(140, 40, 20, 20);
    endtask

    task automatic test_random_full_pressure();
        run_random_mix(110, 60, 10, 10);
    endtask

    task automatic test_random_drain();
        run_random_mix(90, 20, 40, 25);
    endtask

    task automatic test_random_back_to_back();
        steady = 1'b1;
        run_random_mix(90, 40, 20, 20);
        steady = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_queue();
        test_fill_to_full();
        test_remove_wraparound();
        test_random_traffic();
        test_random_full_pressure();
        test_random_drain();
        test_random_back_to_back();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DEPTH + 8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
